// ===== rtl/seven_segment_number_formatter_macros.svh =====
// Assertion macros used by the formatter's top level.
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SSNF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("formatter check failed");
// Next-cycle implication, checked out of reset.
`define SSNF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("formatter check failed");
`else
`define SSNF_ASSERT_IMPL(lbl, ante, cons)
`define SSNF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/ssnf_pkg.sv =====
// Shared types, constants and the segment table of the number formatter.
package ssnf_pkg;

  localparam int MAG_W = 24;
  localparam int SEG_W = 8;
  localparam int Q_W   = 15;
  localparam int DEC_W = 14;

  // Operation codes.
  localparam logic [2:0] OP_DEC_POINT = 3'd0;
  localparam logic [2:0] OP_DEC       = 3'd1;
  localparam logic [2:0] OP_HEX       = 3'd2;
  localparam logic [2:0] OP_HEADER    = 3'd3;
  localparam logic [2:0] OP_DASHES    = 3'd4;

  // Configuration register indexes.
  localparam logic [0:0] REG_POINT_MASK = 1'b0;
  localparam logic [0:0] REG_DASH_CODE  = 1'b1;

  // Decimal ranges; the code is also the digit that carries the point.
  localparam logic [1:0] SCALE_UNITS     = 2'd0;
  localparam logic [1:0] SCALE_TENS      = 2'd1;
  localparam logic [1:0] SCALE_HUNDREDS  = 2'd2;
  localparam logic [1:0] SCALE_THOUSANDS = 2'd3;

  localparam logic [MAG_W-1:0] LIMIT_TENS      = 24'd10000;
  localparam logic [MAG_W-1:0] LIMIT_HUNDREDS  = 24'd100000;
  localparam logic [MAG_W-1:0] LIMIT_THOUSANDS = 24'd1000000;

  // Reciprocals for division by 10, 100 and 1000 of a 24-bit magnitude.
  localparam int         RECIP_W     = 31;
  localparam int         RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_10   = 31'd1717986919;
  localparam logic [RECIP_W-1:0] RECIP_100  = 31'd171798692;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 31'd17179870;

  // Reciprocals for splitting a value below 10000 into digits.
  localparam logic [DEC_W-1:0] RECIP_H = 14'd10486;
  localparam int               SHIFT_H = 20;
  localparam logic [DEC_W-1:0] RECIP_N = 14'd13108;
  localparam int               SHIFT_N = 17;
  localparam logic [6:0]       RECIP_D = 7'd103;
  localparam int               SHIFT_D = 10;

  localparam logic [DEC_W-1:0] DEC_MAX = 14'd9999;
  localparam logic [DEC_W-1:0] HDR_MAX = 14'd999;

  localparam logic [SEG_W-1:0] POINT_MASK_RESET = 8'd1;
  localparam logic [SEG_W-1:0] DASH_CODE_RESET  = 8'd253;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic             valid;
    logic [2:0]       op;
    logic             dash;
    logic [1:0]       scale;
    logic [SEG_W-1:0] hdr;
  } ssnf_ctl_t;

  // Active-low segment code for one hex digit.
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] nib);
    logic [SEG_W-1:0] code;
    case (nib)
      4'h0: code = 8'h03;
      4'h1: code = 8'h9f;
      4'h2: code = 8'h25;
      4'h3: code = 8'h0d;
      4'h4: code = 8'h99;
      4'h5: code = 8'h49;
      4'h6: code = 8'h41;
      4'h7: code = 8'h1f;
      4'h8: code = 8'h01;
      4'h9: code = 8'h09;
      4'ha: code = 8'h11;
      4'hb: code = 8'hc1;
      4'hc: code = 8'h63;
      4'hd: code = 8'h85;
      4'he: code = 8'h61;
      default: code = 8'h71;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/ssnf_scale.sv =====
// Range select and reciprocal divide: the first two pipeline stages.
module ssnf_scale
  import ssnf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [2:0]        op,
  input  logic [24:0]       value_milli,
  input  logic [SEG_W-1:0]  hdr,
  output ssnf_ctl_t         ctl_o,
  output logic [Q_W-1:0]    q_o
);

  logic [MAG_W-1:0]   mag;
  logic               dash;
  logic [1:0]         scale;
  logic [RECIP_W-1:0] recip;

  ssnf_ctl_t          a_ctl_r, a_ctl_nxt;
  logic [MAG_W-1:0]   a_mag_r;
  logic [RECIP_W-1:0] a_recip_r;

  logic [54:0]        prod;
  logic [Q_W-1:0]     q_nxt;
  ssnf_ctl_t          b_ctl_r;
  logic [Q_W-1:0]     b_q_r;

  // Sign, the dashes code and unused codes force dashes; decimal modes pick a range, the others divide by 1000.
  always_comb begin
    mag  = value_milli[MAG_W-1:0];
    dash = value_milli[24] || (op > OP_HEADER);
    if (op == OP_DEC_POINT || op == OP_DEC) begin
      if (mag < LIMIT_TENS) begin
        scale = SCALE_UNITS;
      end else if (mag < LIMIT_HUNDREDS) begin
        scale = SCALE_TENS;
      end else if (mag < LIMIT_THOUSANDS) begin
        scale = SCALE_HUNDREDS;
      end else begin
        scale = SCALE_THOUSANDS;
      end
    end else begin
      scale = SCALE_THOUSANDS;
    end
    case (scale)
      SCALE_TENS:     recip = RECIP_10;
      SCALE_HUNDREDS: recip = RECIP_100;
      default:        recip = RECIP_1000;
    endcase
    a_ctl_nxt = '{valid: take, op: op, dash: dash, scale: scale, hdr: hdr};
  end

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r.valid <= 1'b0;
    end else begin
      a_ctl_r.valid <= a_ctl_nxt.valid;
    end
    a_ctl_r.op    <= a_ctl_nxt.op;
    a_ctl_r.dash  <= a_ctl_nxt.dash;
    a_ctl_r.scale <= a_ctl_nxt.scale;
    a_ctl_r.hdr   <= a_ctl_nxt.hdr;
    a_mag_r       <= mag;
    a_recip_r     <= recip;
  end

  // Quotient by multiply and shift; the smallest range passes through.
  assign prod = {31'b0, a_mag_r} * {24'b0, a_recip_r};
  assign q_nxt = (a_ctl_r.scale == SCALE_UNITS) ? a_mag_r[Q_W-1:0]
                                                : prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

  // Stage two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r.valid <= 1'b0;
    end else begin
      b_ctl_r.valid <= a_ctl_r.valid;
    end
    b_ctl_r.op    <= a_ctl_r.op;
    b_ctl_r.dash  <= a_ctl_r.dash;
    b_ctl_r.scale <= a_ctl_r.scale;
    b_ctl_r.hdr   <= a_ctl_r.hdr;
    b_q_r         <= q_nxt;
  end

  assign ctl_o = b_ctl_r;
  assign q_o   = b_q_r;

endmodule

// ===== rtl/ssnf_split.sv =====
// Saturation and the first digit split: the third pipeline stage.
module ssnf_split
  import ssnf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  ssnf_ctl_t       ctl_i,
  input  logic [Q_W-1:0]  q_i,
  output ssnf_ctl_t       ctl_o,
  output logic [Q_W-1:0]  disp_o,
  output logic [6:0]      hund_o,
  output logic [9:0]      tens_o
);

  logic [DEC_W-1:0] limit;
  logic [DEC_W-1:0] sat;
  logic [Q_W-1:0]   disp_nxt;
  logic [27:0]      h_prod;
  logic [27:0]      n_prod;

  ssnf_ctl_t        c_ctl_r;
  logic [Q_W-1:0]   c_disp_r;
  logic [6:0]       c_hund_r;
  logic [9:0]       c_tens_r;

  // Clamp to the digits available, then divide by 100 and by 10; hex words pass to the display unclamped.
  always_comb begin
    limit = (ctl_i.op == OP_HEADER) ? HDR_MAX : DEC_MAX;
    sat   = (q_i > {1'b0, limit}) ? limit : q_i[DEC_W-1:0];
    disp_nxt = (ctl_i.op == OP_HEX) ? q_i : {1'b0, sat};
    h_prod = {14'b0, sat} * {14'b0, RECIP_H};
    n_prod = {14'b0, sat} * {14'b0, RECIP_N};
  end

  // Stage three registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r.valid <= 1'b0;
    end else begin
      c_ctl_r.valid <= ctl_i.valid;
    end
    c_ctl_r.op    <= ctl_i.op;
    c_ctl_r.dash  <= ctl_i.dash;
    c_ctl_r.scale <= ctl_i.scale;
    c_ctl_r.hdr   <= ctl_i.hdr;
    c_disp_r      <= disp_nxt;
    c_hund_r      <= h_prod[SHIFT_H+6:SHIFT_H];
    c_tens_r      <= n_prod[SHIFT_N+9:SHIFT_N];
  end

  assign ctl_o  = c_ctl_r;
  assign disp_o = c_disp_r;
  assign hund_o = c_hund_r;
  assign tens_o = c_tens_r;

endmodule

// ===== rtl/ssnf_encode.sv =====
// Digit extraction, segment encoding and the output registers.
module ssnf_encode
  import ssnf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ssnf_ctl_t         ctl_i,
  input  logic [Q_W-1:0]    disp_i,
  input  logic [6:0]        hund_i,
  input  logic [9:0]        tens_i,
  input  logic [SEG_W-1:0]  point_mask,
  input  logic [SEG_W-1:0]  dash_code,
  output logic              valid_o,
  output logic [SEG_W-1:0]  first_o,
  output logic [SEG_W-1:0]  second_o,
  output logic [SEG_W-1:0]  third_o,
  output logic [SEG_W-1:0]  fourth_o
);

  logic [13:0]      thou_prod;
  logic [3:0]       thou;
  logic [6:0]       hund_lo;
  logic [9:0]       tens_lo;
  logic [DEC_W-1:0] unit_lo;
  logic [SEG_W-1:0] code [4];

  logic             valid_r;
  logic [SEG_W-1:0] first_r;
  logic [SEG_W-1:0] second_r;
  logic [SEG_W-1:0] third_r;
  logic [SEG_W-1:0] fourth_r;

  // Remaining digits from the quotients of the previous stage.
  always_comb begin
    thou_prod = {7'b0, hund_i} * {7'b0, RECIP_D};
    thou      = thou_prod[SHIFT_D+3:SHIFT_D];
    hund_lo   = hund_i - ({3'b0, thou} * 7'd10);
    tens_lo   = tens_i - ({3'b0, hund_i} * 10'd10);
    unit_lo   = disp_i[DEC_W-1:0] - ({4'b0, tens_i} * 14'd10);
  end

  // Segment codes per mode, point and dashes on top.
  always_comb begin
    code[0] = seg_code(thou);
    code[1] = seg_code(hund_lo[3:0]);
    code[2] = seg_code(tens_lo[3:0]);
    code[3] = seg_code(unit_lo[3:0]);
    case (ctl_i.op)
      OP_HEX: begin
        code[0] = seg_code({1'b0, disp_i[14:12]});
        code[1] = seg_code(disp_i[11:8]);
        code[2] = seg_code(disp_i[7:4]);
        code[3] = seg_code(disp_i[3:0]);
      end
      OP_HEADER: begin
        code[0] = ctl_i.hdr;
      end
      OP_DEC_POINT: begin
        code[ctl_i.scale] = code[ctl_i.scale] & ~point_mask;
      end
      default: begin
      end
    endcase
    if (ctl_i.dash) begin
      code[0] = dash_code;
      code[1] = dash_code;
      code[2] = dash_code;
      code[3] = dash_code;
    end
  end

  // Output word registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
    first_r  <= code[0];
    second_r <= code[1];
    third_r  <= code[2];
    fourth_r <= code[3];
  end

  assign valid_o  = valid_r;
  assign first_o  = first_r;
  assign second_o = second_r;
  assign third_o  = third_r;
  assign fourth_o = fourth_r;

endmodule

// ===== rtl/seven_segment_number_formatter.sv =====
// Top level of the four-digit seven-segment number formatter.
// Each accepted word passes through four register stages: range, divide, digit split and
// encode.
// Throughput: one word per cycle, back to back; busy never rises after reset.
// Reset clears the valid bits, sets point_mask to 1 and dash_code to 253, and holds busy
// high until the first edge that sees reset released; the receiver cannot stall.
module seven_segment_number_formatter
  import ssnf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [24:0] in_value_milli,
  input  logic [SEG_W-1:0]   in_header_code,
  output logic               out_valid,
  output logic [SEG_W-1:0]   out_digit_first,
  output logic [SEG_W-1:0]   out_digit_second,
  output logic [SEG_W-1:0]   out_digit_third,
  output logic [SEG_W-1:0]   out_digit_fourth,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [SEG_W-1:0]   cfg_wdata
);

`include "seven_segment_number_formatter_macros.svh"

  logic             busy_r;
  logic             take_word;
  logic [SEG_W-1:0] point_mask_r;
  logic [SEG_W-1:0] dash_code_r;
  logic             all_dash;

  ssnf_ctl_t        scale_ctl;
  logic [Q_W-1:0]   scale_q;
  ssnf_ctl_t        split_ctl;
  logic [Q_W-1:0]   split_disp;
  logic [6:0]       split_hund;
  logic [9:0]       split_tens;

  // Busy only while in reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign take_word = start && !busy_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_mask_r <= POINT_MASK_RESET;
      dash_code_r  <= DASH_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT_MASK: point_mask_r <= cfg_wdata;
        REG_DASH_CODE:  dash_code_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ssnf_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take_word),
    .op          (in_operation),
    .value_milli (in_value_milli),
    .hdr         (in_header_code),
    .ctl_o       (scale_ctl),
    .q_o         (scale_q)
  );

  ssnf_split u_split (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (scale_ctl),
    .q_i    (scale_q),
    .ctl_o  (split_ctl),
    .disp_o (split_disp),
    .hund_o (split_hund),
    .tens_o (split_tens)
  );

  ssnf_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (split_ctl),
    .disp_i     (split_disp),
    .hund_i     (split_hund),
    .tens_i     (split_tens),
    .point_mask (point_mask_r),
    .dash_code  (dash_code_r),
    .valid_o    (out_valid),
    .first_o    (out_digit_first),
    .second_o   (out_digit_second),
    .third_o    (out_digit_third),
    .fourth_o   (out_digit_fourth)
  );

  // All four digits show the dash code.
  assign all_dash = (out_digit_first == dash_code_r) && (out_digit_second == dash_code_r) &&
                    (out_digit_third == dash_code_r) && (out_digit_fourth == dash_code_r);

  // Every accepted word comes out after the pipeline depth.
  `SSNF_ASSERT_IMPL(a_word_out, take_word, ##4 out_valid)
  // No result appears unless a word was accepted the pipeline depth earlier.
  `SSNF_ASSERT_IMPL(a_no_stray, out_valid, $past(take_word, 4))
  // A negative value shows dashes on all four digits.
  `SSNF_ASSERT_IMPL(a_neg_dash, take_word && in_value_milli[24], ##4 all_dash)

endmodule

// ===== test/tb_seven_segment_number_formatter.sv =====
// Testbench for the four-digit seven-segment number formatter.
`timescale 1ns / 100ps

module tb_seven_segment_number_formatter
  import ssnf_pkg::*;
();

  // Cycles from an accepted word to its result.
  localparam int RESULT_LATENCY = 4;

  // Active-low segment codes for 0..F, digit 0 in the low byte.
  localparam logic [16*SEG_W-1:0] DIGIT_SEGMENTS = {
    8'h71, 8'h61, 8'h85, 8'h63, 8'hc1, 8'h11, 8'h09, 8'h01,
    8'h1f, 8'h41, 8'h49, 8'h99, 8'h0d, 8'h25, 8'h9f, 8'h03
  };

  typedef struct packed {
    logic [SEG_W-1:0] first;
    logic [SEG_W-1:0] second;
    logic [SEG_W-1:0] third;
    logic [SEG_W-1:0] fourth;
  } digits_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_operation;
  logic signed [24:0] in_value_milli;
  logic [SEG_W-1:0]   in_header_code;
  logic               out_valid;
  logic [SEG_W-1:0]   out_digit_first;
  logic [SEG_W-1:0]   out_digit_second;
  logic [SEG_W-1:0]   out_digit_third;
  logic [SEG_W-1:0]   out_digit_fourth;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [SEG_W-1:0]   cfg_wdata;

  // Register copies and the queue of displays still to come.
  logic [SEG_W-1:0] point_mask_q;
  logic [SEG_W-1:0] dash_code_q;
  digits_t          pending_digits[$];
  int               error_count;
  bit               idle_enable;

  seven_segment_number_formatter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value_milli   (in_value_milli),
    .in_header_code   (in_header_code),
    .out_valid        (out_valid),
    .out_digit_first  (out_digit_first),
    .out_digit_second (out_digit_second),
    .out_digit_third  (out_digit_third),
    .out_digit_fourth (out_digit_fourth),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Segment code of the lowest decimal digit of a number.
  function automatic logic [SEG_W-1:0] decimal_code(input int unsigned n);
    return DIGIT_SEGMENTS[(n % 10) * SEG_W +: SEG_W];
  endfunction

  // Segment code of one hex digit.
  function automatic logic [SEG_W-1:0] hex_code(input logic [3:0] nib);
    return DIGIT_SEGMENTS[nib * SEG_W +: SEG_W];
  endfunction

  // Works out the four segment codes that one word should produce.
  function automatic digits_t format_value(input logic [2:0] op, input logic [24:0] value,
                                           input logic [SEG_W-1:0] hdr);
    logic [SEG_W-1:0] code [4];
    logic [31:0]      whole;
    int unsigned      mag;
    int unsigned      shown;
    int unsigned      point_pos;
    mag   = value[23:0];
    whole = mag / 1000;
    if (value[24] || op > OP_HEADER) begin
      for (int i = 0; i < 4; i++) code[i] = dash_code_q;
    end else if (op == OP_DEC_POINT || op == OP_DEC) begin
      // Pick the range so that four digits fill the display.
      if (mag < 10000) begin
        shown = mag;
        point_pos = 0;
      end else if (mag < 100000) begin
        shown = mag / 10;
        point_pos = 1;
      end else if (mag < 1000000) begin
        shown = mag / 100;
        point_pos = 2;
      end else begin
        shown = (whole > 9999) ? 9999 : whole;
        point_pos = 3;
      end
      code[0] = decimal_code(shown / 1000);
      code[1] = decimal_code(shown / 100);
      code[2] = decimal_code(shown / 10);
      code[3] = decimal_code(shown);
      if (op == OP_DEC_POINT) code[point_pos] = code[point_pos] & ~point_mask_q;
    end else if (op == OP_HEX) begin
      code[0] = hex_code(whole[15:12]);
      code[1] = hex_code(whole[11:8]);
      code[2] = hex_code(whole[7:4]);
      code[3] = hex_code(whole[3:0]);
    end else begin
      // Header code, then the integer part clipped to three digits.
      shown = (whole > 999) ? 999 : whole;
      code[0] = hdr;
      code[1] = decimal_code(shown / 100);
      code[2] = decimal_code(shown / 10);
      code[3] = decimal_code(shown);
    end
    return {code[0], code[1], code[2], code[3]};
  endfunction

  // Offers one word, waits until it is taken and records its expected display.
  task automatic send_word(input logic [2:0] op, input logic [24:0] value,
                           input logic [SEG_W-1:0] hdr);
    if (idle_enable) begin
      while ($urandom_range(0, 99) < 9) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_value_milli <= value;
    in_header_code <= hdr;
    do @(posedge clk); while (busy);
    pending_digits.push_back(format_value(op, value, hdr));
  endtask

  // Writes one register once every pending display has come out.
  task automatic write_reg(input logic [0:0] idx, input logic [SEG_W-1:0] data);
    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POINT_MASK) point_mask_q = data;
    else dash_code_q = data;
  endtask

  task automatic write_config(input logic [SEG_W-1:0] mask, input logic [SEG_W-1:0] dash);
    write_reg(REG_POINT_MASK, mask);
    write_reg(REG_DASH_CODE, dash);
  endtask

  // Random value, spread over the ranges, their boundaries and negatives.
  function automatic logic [24:0] rand_value();
    logic [31:0] r;
    int          boundary;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return {1'b1, r[23:0]};
      1: return 25'($urandom_range(0, 9999));
      2: return 25'($urandom_range(10000, 99999));
      3: return 25'($urandom_range(100000, 999999));
      4: return 25'($urandom_range(1000000, 16777215));
      5: begin
        case ($urandom_range(0, 4))
          0: boundary = 10000;
          1: boundary = 100000;
          2: boundary = 1000000;
          3: boundary = 10000000;
          default: boundary = 16777214;
        endcase
        return 25'(boundary + $urandom_range(0, 3) - 2);
      end
      default: return {1'b0, r[23:0]};
    endcase
  endfunction

  // Mostly the four formatting modes, sometimes dashes or unused codes.
  function automatic logic [2:0] rand_operation();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return 3'(r % 4);
    if (r < 18) return OP_DASHES;
    return 3'($urandom_range(5, 7));
  endfunction

  // Range edges, every mode, saturation and negative values at reset settings.
  task automatic test_directed_ranges();
    send_word(OP_DEC_POINT, 0, 8'h00);
    send_word(OP_DEC_POINT, 9999, 8'h00);
    send_word(OP_DEC_POINT, 10000, 8'h00);
    send_word(OP_DEC_POINT, 99999, 8'h00);
    send_word(OP_DEC_POINT, 100000, 8'h00);
    send_word(OP_DEC_POINT, 999999, 8'h00);
    send_word(OP_DEC_POINT, 1000000, 8'h00);
    send_word(OP_DEC_POINT, 9999999, 8'h00);
    send_word(OP_DEC_POINT, 10000000, 8'h00);
    send_word(OP_DEC_POINT, 16777215, 8'h00);
    send_word(OP_DEC, 1234, 8'h00);
    send_word(OP_DEC, 16777215, 8'h00);
    send_word(OP_HEX, 0, 8'h00);
    send_word(OP_HEX, 16777215, 8'h00);
    send_word(OP_HEX, 11259375, 8'h00);
    send_word(OP_HEADER, 0, 8'h00);
    send_word(OP_HEADER, 999999, 8'hff);
    send_word(OP_HEADER, 1000000, 8'h5a);
    send_word(OP_HEADER, 16777215, 8'ha5);
    send_word(OP_DASHES, 4321, 8'h00);
    send_word(3'd5, 7, 8'h00);
    send_word(3'd7, 16777215, 8'hff);
    send_word(OP_DEC_POINT, -1, 8'h00);
    send_word(OP_HEX, -16777216, 8'h00);
    send_word(OP_HEADER, -1000, 8'h12);
  endtask

  // One register setting, probed with the point at each digit and with dashes.
  task automatic probe_setting(input logic [SEG_W-1:0] mask, input logic [SEG_W-1:0] dash);
    write_config(mask, dash);
    send_word(OP_DEC_POINT, 5, 8'h00);
    send_word(OP_DEC_POINT, 12345, 8'h00);
    send_word(OP_DEC_POINT, 123456, 8'h00);
    send_word(OP_DEC_POINT, 5000000, 8'h00);
    send_word(OP_DEC, -5, 8'h00);
    send_word(OP_DASHES, 42, 8'h00);
  endtask

  // Extremes of both registers, a mixed pair and the reset values.
  task automatic test_register_settings();
    probe_setting(8'hff, 8'h00);
    probe_setting(8'h00, 8'hff);
    probe_setting(8'h80, 8'h7f);
    probe_setting(POINT_MASK_RESET, DASH_CODE_RESET);
  endtask

  // Random words in phases with random settings; one phase runs without gaps.
  task automatic test_random_formatting(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      idle_enable = (p != 2);
      for (int i = 0; i < per_phase; i++) begin
        send_word(rand_operation(), rand_value(), 8'($urandom_range(0, 255)));
      end
    end
    idle_enable = 1'b1;
  endtask

  // Compares one digit and reports a difference.
  task automatic compare_digit(input string label, input logic [SEG_W-1:0] want,
                               input logic [SEG_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s digit mismatch, expected %h, actual %h", $time, label, want, got);
      error_count++;
    end
  endtask

  // Each result strobe is checked against the oldest expected display.
  always @(posedge clk) begin
    digits_t want;
    if (rst_n && out_valid) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %h %h %h", $time,
                 out_digit_first, out_digit_second, out_digit_third, out_digit_fourth);
        error_count++;
      end else begin
        want = pending_digits.pop_front();
        compare_digit("first", want.first, out_digit_first);
        compare_digit("second", want.second, out_digit_second);
        compare_digit("third", want.third, out_digit_third);
        compare_digit("fourth", want.fourth, out_digit_fourth);
      end
    end
  end

  // Test sequence.
  initial begin
    error_count    = 0;
    idle_enable    = 1'b1;
    point_mask_q   = POINT_MASK_RESET;
    dash_code_q    = DASH_CODE_RESET;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_operation   <= OP_DEC_POINT;
    in_value_milli <= '0;
    in_header_code <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_POINT_MASK;
    cfg_wdata      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ranges();
    test_register_settings();
    test_random_formatting(6, 150);

    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== seven_segment_number_formatter.f =====
+incdir+rtl
rtl/ssnf_pkg.sv
rtl/ssnf_scale.sv
rtl/ssnf_split.sv
rtl/ssnf_encode.sv
rtl/seven_segment_number_formatter.sv
test/tb_seven_segment_number_formatter.sv
